[rtl/vcodec_pkg.sv]
// vcodec_pkg: types and constants shared by the varint codec modules.
// Holds the beat structs, result kind codes, controller states and the
// command/status bundles. Depends on nothing.
package vcodec_pkg;

  localparam int unsigned GroupW   = 7;
  localparam int unsigned MaxBytes = 10;
  localparam int unsigned NarrowBytes = 5;
  localparam int unsigned CntW     = 4;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_VALUE    = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [63:0] in_value;
    logic [7:0]         in_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic [7:0]         out_byte;
    logic signed [63:0] out_value;
    logic [3:0]         enc_length;
    logic               last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENC,
    ST_DEC
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_enc;
    logic load_dec;
    logic step_enc;
    logic show_enc;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dec_emit;
    logic enc_last;
  } status_t;

endpackage

[rtl/varint_codec.sv]
// varint_codec: top level of the unsigned LEB128 varint/varlong codec.
// Joins vcodec_ctrl and vcodec_dp; types come from vcodec_pkg.
//
//   channel | direction | beat         | accepted when
//   --------+-----------+--------------+---------------------------
//   in      | input     | vcodec_pkg::in_t  | in_valid_i & in_ready_o
//   out     | output    | vcodec_pkg::out_t | out_valid_o & out_ready_i
//   cfg     | input     | wide_mode bit     | cfg_valid_i & cfg_ready_o
//
// A continuing decode byte is absorbed into the accumulator and the block
// stays ready. A terminating or overflowing decode byte gives one output
// beat. An encode gives one beat for each encoded byte (1 to 10), set by
// the single shift register that emits them.
// Input is held off (in_ready_o low) while any output beat is pending.
// Reset clears the mode (32-bit), the accumulator and the byte count.
// Output stalls hold the current beat unchanged; cfg writes are always taken.
module varint_codec (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vcodec_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vcodec_pkg::out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i
);

  vcodec_pkg::cmd_t    cmd;
  vcodec_pkg::status_t status;

  // Mode register never back-pressures
  assign cfg_ready_o = 1'b1;

  vcodec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Advance the accumulator only on an accepted decode beat; hold it over encodes
  vcodec_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

[rtl/vcodec_ctrl.sv]
// vcodec_ctrl: sequencing state machine of the varint codec.
// Drives handshakes and datapath commands. Depends on vcodec_pkg.
module vcodec_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                req_type_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  vcodec_pkg::status_t status_i,
  output vcodec_pkg::cmd_t    cmd_o
);

  vcodec_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcodec_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vcodec_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == vcodec_pkg::REQ_ENCODE) begin
            state_d = vcodec_pkg::ST_ENC;
          end else if (status_i.dec_emit) begin
            state_d = vcodec_pkg::ST_DEC;
          end
        end
      end
      vcodec_pkg::ST_ENC: begin
        if (out_ready_i && status_i.enc_last) begin
          state_d = vcodec_pkg::ST_IDLE;
        end
      end
      vcodec_pkg::ST_DEC: begin
        if (out_ready_i) begin
          state_d = vcodec_pkg::ST_IDLE;
        end
      end
      default: state_d = vcodec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      vcodec_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_enc = in_valid_i && (req_type_i == vcodec_pkg::REQ_ENCODE);
        cmd_o.load_dec = in_valid_i && (req_type_i == vcodec_pkg::REQ_DECODE);
      end
      vcodec_pkg::ST_ENC: begin
        out_valid_o    = 1'b1;
        cmd_o.show_enc = 1'b1;
        cmd_o.step_enc = out_ready_i;
      end
      vcodec_pkg::ST_DEC: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/vcodec_dp.sv]
// vcodec_dp: datapath of the varint codec - mode register, decode
// accumulator, encode shift register and result register. Depends on vcodec_pkg.
module vcodec_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  vcodec_pkg::in_t     in_data_i,
  input  vcodec_pkg::cmd_t    cmd_i,
  output vcodec_pkg::status_t status_o,
  output vcodec_pkg::out_t    out_data_o
);

  logic                          wide_q;
  logic [63:0]                   acc_q, acc_d;
  logic [vcodec_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [63:0]                   enc_q;
  logic [3:0]                    len_q, idx_q;
  vcodec_pkg::out_t              res_q, res_d;

  // Decode byte evaluation
  logic [3:0]  count, limit;
  logic        more, ovf;
  logic [63:0] placed, acc_new, dec_val;

  // Encode length search
  logic [63:0] enc_val;
  logic [9:0]  grp_nz;
  logic [3:0]  enc_len;

  always_comb begin
    count  = cnt_q + 4'd1;
    limit  = wide_q ? 4'(vcodec_pkg::MaxBytes) : 4'(vcodec_pkg::NarrowBytes);
    more   = in_data_i.in_byte[7];
    ovf    = (count > limit) || (more && (count >= limit));
    placed = '0;
    for (int k = 0; k < 9; k++) begin
      if (cnt_q == 4'(k)) begin
        placed[k*vcodec_pkg::GroupW +: vcodec_pkg::GroupW] = in_data_i.in_byte[6:0];
      end
    end
    if (cnt_q == 4'd9) begin
      placed[63] = in_data_i.in_byte[0];
    end
    acc_new = acc_q | placed;
    dec_val = wide_q ? acc_new : {{32{acc_new[31]}}, acc_new[31:0]};
  end

  always_comb begin
    enc_val = wide_q ? in_data_i.in_value : {32'd0, in_data_i.in_value[31:0]};
    for (int k = 0; k < 9; k++) begin
      grp_nz[k] = |enc_val[k*vcodec_pkg::GroupW +: vcodec_pkg::GroupW];
    end
    grp_nz[9] = enc_val[63];
    enc_len = 4'd1;
    for (int k = 1; k < 10; k++) begin
      if (grp_nz[k]) begin
        enc_len = 4'(k + 1);
      end
    end
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    res_d = res_q;
    if (cmd_i.load_dec) begin
      res_d.out_byte   = '0;
      res_d.enc_length = count;
      res_d.last       = 1'b1;
      if (ovf) begin
        acc_d            = '0;
        cnt_d            = '0;
        res_d.out_kind   = vcodec_pkg::KIND_OVERFLOW;
        res_d.out_value  = '0;
      end else if (more) begin
        acc_d = acc_new;
        cnt_d = count;
      end else begin
        acc_d            = '0;
        cnt_d            = '0;
        res_d.out_kind   = vcodec_pkg::KIND_VALUE;
        res_d.out_value  = dec_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b0;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        wide_q <= cfg_data_i;
      end
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.load_enc) begin
      enc_q <= enc_val;
      len_q <= enc_len;
      idx_q <= '0;
    end else if (cmd_i.step_enc) begin
      enc_q <= enc_q >> vcodec_pkg::GroupW;
      idx_q <= idx_q + 4'd1;
    end
  end

  always_comb begin
    status_o.dec_emit = ovf || !more;
    status_o.enc_last = (idx_q + 4'd1) == len_q;
    if (cmd_i.show_enc) begin
      out_data_o.out_kind   = vcodec_pkg::KIND_BYTE;
      out_data_o.out_byte   = {!status_o.enc_last, enc_q[6:0]};
      out_data_o.out_value  = '0;
      out_data_o.enc_length = len_q;
      out_data_o.last       = status_o.enc_last;
    end else begin
      out_data_o = res_q;
    end
  end

endmodule

[rtl/vcodec_checker.sv]
// vcodec_checker: port-level checks for varint_codec, attached by bind.
// Depends on vcodec_pkg.
module vcodec_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input vcodec_pkg::out_t out_data_o
);

  // Input is never taken while a beat is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while output beat pending");

  // A stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // Continuation bit set exactly on non-final encoded bytes
  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind == vcodec_pkg::KIND_BYTE |->
      out_data_o.out_byte[7] == !out_data_o.last)
    else $error("continuation bit disagrees with last");

  // Decode results are single beats
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind != vcodec_pkg::KIND_BYTE |-> out_data_o.last)
    else $error("decode result not flagged last");

  // After a final beat is taken, the block is ready for input
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last |=> in_ready_o)
    else $error("not ready after final beat");

endmodule

bind varint_codec vcodec_checker u_vcodec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[tb/tb_top.sv]
// tb_top: self-checking testbench for the varint_codec LEB128 codec.
// Drives request beats, predicts every output beat in both modes and checks them.
// Depends on vcodec_pkg and the varint_codec RTL only.
module tb_top;

  localparam int Limit        = 200000; // cycles before the run is declared hung
  localparam int SettleCycles = 4;      // quiet cycles before a mode write or the end
  localparam int LongHold     = 300;    // length of the one long output stall

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;

  logic in_valid  = 1'b0;
  logic in_ready;
  vcodec_pkg::in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vcodec_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data  = 1'b0;

  // Predictor state: mode bit plus the decode accumulator and bit position.
  logic       wide_q   = 1'b0;
  logic [63:0] dec_acc = '0;
  logic [6:0]  dec_pos = '0;

  vcodec_pkg::in_t  items_pending[$];  // request beats not yet offered
  vcodec_pkg::out_t beats_due[$];      // output beats predicted but not yet seen

  int send_gap      = 0;
  int send_gap_max  = 3;
  int recv_gap      = 0;
  int recv_gap_max  = 3;
  int recv_draw     = 0;
  bit send_free     = 1'b0;
  logic hold_armed  = 1'b0;
  logic hold_done   = 1'b0;
  int hold_cnt      = 0;

  int errors = 0;
  int cycles = 0;
  int queued = 0;
  int n_enc = 0, n_dec = 0, n_beats = 0, n_values = 0, n_ovf = 0;

  varint_codec dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // Work out the output beats that one accepted request causes and queue them.
  task automatic expect_beats_for(input vcodec_pkg::in_t item);
    logic [63:0] val;
    logic [63:0] rest;
    logic [63:0] word;
    int          nbytes;
    int          limit;
    int          count;
    logic        more;
    vcodec_pkg::out_t beat;
    if (item.req_type == vcodec_pkg::REQ_ENCODE) begin
      n_enc++;
      // Narrow mode takes the low 32 bits as unsigned.
      val = wide_q ? item.in_value : {32'd0, item.in_value[31:0]};
      rest = val;
      nbytes = 0;
      do begin
        rest = rest >> 7;
        nbytes++;
      end while (rest != 0);
      for (int k = 0; k < nbytes; k++) begin
        beat = '0;
        beat.out_kind   = vcodec_pkg::KIND_BYTE;
        beat.out_byte   = {(val >> 7) != 0, val[6:0]};
        beat.enc_length = 4'(nbytes);
        beat.last       = (k == nbytes - 1);
        val = val >> 7;
        beats_due = {beats_due, beat};
      end
    end else begin
      n_dec++;
      limit = wide_q ? int'(vcodec_pkg::MaxBytes) : int'(vcodec_pkg::NarrowBytes);
      count = dec_pos / 7 + 1;
      more  = item.in_byte[7];
      beat  = '0;
      // Too many bytes for the mode, or the final permitted byte still continues:
      // flag overflow and restart. The first arm only fires after a mode change.
      if (count > limit || (more && count >= limit)) begin
        dec_acc = '0;
        dec_pos = '0;
        beat.out_kind   = vcodec_pkg::KIND_OVERFLOW;
        beat.enc_length = 4'(count);
        beat.last       = 1'b1;
        beats_due = {beats_due, beat};
        n_ovf++;
      end else begin
        // Data bits above bit 63 fall off the shift; above bit 31 the narrow
        // mask drops them later.
        if (dec_pos < 64) dec_acc = dec_acc | ({57'd0, item.in_byte[6:0]} << dec_pos);
        if (more) begin
          dec_pos = 7'(dec_pos + 7);
        end else begin
          word = wide_q ? dec_acc : {{32{dec_acc[31]}}, dec_acc[31:0]};
          dec_acc = '0;
          dec_pos = '0;
          beat.out_kind   = vcodec_pkg::KIND_VALUE;
          beat.out_value  = word;
          beat.enc_length = 4'(count);
          beat.last       = 1'b1;
          beats_due = {beats_due, beat};
          n_values++;
        end
      end
    end
  endtask

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_beat(input vcodec_pkg::out_t got);
    vcodec_pkg::out_t want;
    n_beats++;
    if (beats_due.size() == 0) begin
      $display("%0t: unexpected beat, expected none, got %p", $time, got);
      errors++;
    end else begin
      want = beats_due.pop_front();
      compare_field("out_kind",   64'(want.out_kind),   64'(got.out_kind));
      compare_field("out_byte",   64'(want.out_byte),   64'(got.out_byte));
      compare_field("out_value",  want.out_value,       got.out_value);
      compare_field("enc_length", 64'(want.enc_length), 64'(got.enc_length));
      compare_field("last",       64'(want.last),       64'(got.last));
    end
  endtask

  // Request driver: hold each beat until taken, then idle for the drawn gap.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      send_free = !in_valid || in_ready;
      if (in_valid && in_ready) expect_beats_for(in_data);
      if (send_free) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (items_pending.size() > 0) begin
          in_data  <= items_pending.pop_front();
          in_valid <= 1'b1;
          send_gap <= $urandom_range(0, send_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each beat taken, then drop ready for a drawn gap.
  // Once armed, hold ready low for a long stretch so the block backs up.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_beat(out_data);
      if (hold_armed && !hold_done) begin
        out_ready <= 1'b0;
        if (hold_cnt == LongHold) hold_done <= 1'b1;
        else hold_cnt <= hold_cnt + 1;
      end else if (out_valid && out_ready) begin
        recv_draw = $urandom_range(0, recv_gap_max);
        if (recv_draw != 0) begin
          out_ready <= 1'b0;
          recv_gap  <= recv_draw - 1;
        end
      end else if (!out_ready) begin
        if (recv_gap > 0) recv_gap <= recv_gap - 1;
        else out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          w;
    v = {$urandom(), $urandom()};
    // Spread the magnitude so every encoded length turns up.
    w = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(0, 64);
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  task automatic push_enc(input logic [63:0] v);
    vcodec_pkg::in_t item;
    item.req_type = vcodec_pkg::REQ_ENCODE;
    item.in_value = v;
    item.in_byte  = 8'($urandom_range(0, 255));
    items_pending = {items_pending, item};
    queued++;
  endtask

  task automatic push_dec(input logic [7:0] b);
    vcodec_pkg::in_t item;
    item.req_type = vcodec_pkg::REQ_DECODE;
    item.in_value = {$urandom(), $urandom()};
    item.in_byte  = b;
    items_pending = {items_pending, item};
    queued++;
  endtask

  task automatic push_dec_run(input logic [7:0] b, input int n);
    for (int k = 0; k < n; k++) push_dec(b);
  endtask

  // Queue one random group: an encode, a well-formed encoded value to decode,
  // or a run of junk bytes that may overflow or stop half way.
  task automatic push_random_group();
    logic [63:0] u;
    logic [7:0]  b;
    int          sel;
    int          n;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      push_enc(rand_value());
    end else if (sel < 80) begin
      u = rand_value();
      if (!wide_q) u = {32'd0, u[31:0]};
      do begin
        b = {1'b0, u[6:0]};
        u = u >> 7;
        if (u != 0) b[7] = 1'b1;
        push_dec(b);
        // Slip an encode into the middle of a value now and then.
        if ($urandom_range(0, 19) == 0) push_enc(rand_value());
      end while (u != 0);
    end else begin
      n = $urandom_range(1, wide_q ? 11 : 6);
      for (int k = 0; k < n; k++) begin
        b = 8'($urandom_range(0, 255));
        b[7] = (k < n - 1) ? 1'b1 : 1'($urandom_range(0, 1));
        push_dec(b);
      end
    end
  endtask

  // Wait until every request is taken and every beat seen, then let the
  // block settle so a trailing continuing byte has been absorbed.
  task automatic wait_idle();
    do @(posedge clk);
    while (items_pending.size() != 0 || in_valid || beats_due.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    wide_q = m;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Narrow mode: zero, the widest value with upper bits to ignore, a
    // two-byte value, all ones with excess bits, overflow, encode mid-decode.
    set_mode(1'b0);
    push_enc(64'd0);
    push_enc(64'hFFFF_FFFF_FFFF_FFFF);
    push_enc(64'd128);
    push_dec_run(8'hFF, 4);
    push_dec(8'h7F);
    push_dec_run(8'h80, 5);
    push_dec(8'h81);
    push_enc(64'd300);
    push_dec(8'h01);
    // Start a value in narrow mode and finish it in wide mode.
    push_dec_run(8'h81, 2);
    wait_idle();
    set_mode(1'b1);
    push_dec(8'h01);

    // Wide mode: the most negative value, ten-byte overflow, then a value
    // left open across a switch to narrow mode so it overflows on arrival.
    push_enc(64'h8000_0000_0000_0000);
    push_dec_run(8'h80, 10);
    push_dec_run(8'h80, 6);
    wait_idle();
    set_mode(1'b0);
    push_dec(8'h01);
    wait_idle();

    // Random phases, alternating modes and idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph % 2 == 0);
      send_gap_max = (ph == 0 || ph == 3) ? 3 : 0;
      recv_gap_max = (ph == 0 || ph == 2) ? 3 : 0;
      if (ph == 2) hold_armed <= 1'b1;
      start = queued;
      while (queued - start < 95) push_random_group();
      wait_idle();
    end

    errors += beats_due.size();
    $display("Ran %0d encode and %0d decode requests in both modes, %0d beats checked.",
             n_enc, n_dec, n_beats);
    $display("Saw %0d decoded values and %0d overflows, with one long output stall.",
             n_values, n_ovf);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: give up if the run hangs.
  initial begin
    while (cycles < Limit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run timed out after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
rtl/vcodec_pkg.sv
rtl/vcodec_ctrl.sv
rtl/vcodec_dp.sv
rtl/varint_codec.sv
rtl/vcodec_checker.sv
tb/tb_top.sv
